// ===== hdl/tcw_pkg.sv =====
// ---------------------------------------------------------------------------
// tcw_pkg
// Shared constants for the character-cell console: default screen geometry,
// special character codes, reset cell contents and register indexes.
// ---------------------------------------------------------------------------
`default_nettype none

package tcw_pkg;

  localparam int DEF_SCREEN_COLUMNS = 80;
  localparam int DEF_SCREEN_ROWS    = 25;

  localparam int CELL_W = 16;

  localparam logic [7:0] CODE_NEWLINE   = 8'd10;
  localparam logic [7:0] CODE_TAB       = 8'd9;
  localparam logic [7:0] CODE_BACKSPACE = 8'd8;
  localparam logic [7:0] CODE_SPACE     = 8'd32;

  localparam logic [7:0] RESET_ATTR = 8'h07;

  localparam logic FUNC_READ = 1'b1;

  // Register index, taken from paddr[2]
  localparam logic REG_TEXT_ATTR = 1'b0;

endpackage

`default_nettype wire

// ===== hdl/tcw_screen_mem.sv =====
// ---------------------------------------------------------------------------
// tcw_screen_mem
// Screen cell store: one write port, one read port with registered data.
// ---------------------------------------------------------------------------
`default_nettype none

module tcw_screen_mem
  import tcw_pkg::*;
#(
  parameter int DEPTH = DEF_SCREEN_COLUMNS * DEF_SCREEN_ROWS,
  parameter int AW    = $clog2(DEPTH)
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [AW-1:0]     waddr,
  input  wire logic [CELL_W-1:0] wdata,
  input  wire logic              re,
  input  wire logic [AW-1:0]     raddr,
  output logic      [CELL_W-1:0] rdata
);

  logic [CELL_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== hdl/tcw_cursor_next.sv =====
// ---------------------------------------------------------------------------
// tcw_cursor_next
// Cursor update for one put: advance with wrap, then newline, tab and
// backspace handling, then clamp to the last row when the screen scrolls.
// ---------------------------------------------------------------------------
`default_nettype none

module tcw_cursor_next
  import tcw_pkg::*;
#(
  parameter int COLS = DEF_SCREEN_COLUMNS,
  parameter int ROWS = DEF_SCREEN_ROWS
) (
  input  wire logic [$clog2(ROWS)-1:0] row,
  input  wire logic [$clog2(COLS)-1:0] col,
  input  wire logic [7:0]              char_code,
  output logic      [$clog2(ROWS)-1:0] row_nxt,
  output logic      [$clog2(COLS)-1:0] col_nxt,
  output logic                         scroll
);

  localparam int RW  = $clog2(ROWS);
  localparam int CLW = $clog2(COLS);
  // column may overshoot the line end by up to seven during tab alignment
  localparam int CXW = $clog2(COLS + 8);
  localparam int RXW = $clog2(ROWS + 2);

  logic [CXW-1:0] c1;
  logic [CXW-1:0] c2;
  logic [RXW-1:0] r1;
  logic [RXW-1:0] r2;

  always_comb begin
    c1 = CXW'(col) + CXW'(1);
    r1 = RXW'(row);
    if (c1 >= CXW'(COLS)) begin
      c1 = '0;
      r1 = r1 + RXW'(1);
    end
    c2 = c1;
    r2 = r1;
    case (char_code)
      CODE_NEWLINE: begin
        c2 = '0;
        r2 = r1 + RXW'(1);
      end
      CODE_TAB: begin
        c2 = (c1 + CXW'(7)) & ~CXW'(7);
        c2 = c2 + CXW'(1);
        if (c2 >= CXW'(COLS)) begin
          c2 = '0;
          r2 = r1 + RXW'(1);
        end
      end
      CODE_BACKSPACE: begin
        if (c1 != '0) begin
          c2 = (c1 >= CXW'(2)) ? c1 - CXW'(2) : '0;
        end
      end
      default: begin
        c2 = c1;
      end
    endcase
    scroll  = (r2 >= RXW'(ROWS));
    row_nxt = scroll ? RW'(ROWS - 1) : RW'(r2);
    col_nxt = CLW'(c2);
  end

endmodule

`default_nettype wire

// ===== hdl/tcw_seq.sv =====
// ---------------------------------------------------------------------------
// tcw_seq
// Sequencer: clearing pass after reset, cell write and cursor update for a
// put, cell read, cell-by-cell scroll copy and bottom-row fill through a single
// address counter pair, and the result register.
// ---------------------------------------------------------------------------
`default_nettype none

module tcw_seq
  import tcw_pkg::*;
#(
  parameter int COLS = DEF_SCREEN_COLUMNS,
  parameter int ROWS = DEF_SCREEN_ROWS,
  parameter int AW   = $clog2(COLS * ROWS)
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic [7:0]        text_attr,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic              in_func,
  input  wire logic [7:0]        in_char_code,
  input  wire logic [10:0]       in_cell_index,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic      [10:0]       out_cursor_index,
  output logic      [4:0]        out_cursor_row,
  output logic      [6:0]        out_cursor_col,
  output logic                   out_scrolled,
  output logic      [15:0]       out_read_cell,
  output logic                   mem_we,
  output logic      [AW-1:0]     mem_waddr,
  output logic      [CELL_W-1:0] mem_wdata,
  output logic                   mem_re,
  output logic      [AW-1:0]     mem_raddr,
  input  wire logic [CELL_W-1:0] mem_rdata
);

  localparam int CELL_COUNT = COLS * ROWS;
  localparam int RW         = $clog2(ROWS);
  localparam int CLW        = $clog2(COLS);
  localparam int CMPW       = 14;
  localparam logic [AW-1:0] LAST   = AW'(CELL_COUNT - 1);
  localparam logic [AW-1:0] COLS_W = AW'(COLS);

  typedef enum logic [5:0] {
    S_CLEAR  = 6'b000001,
    S_IDLE   = 6'b000010,
    S_FINISH = 6'b000100,
    S_COPY   = 6'b001000,
    S_TAIL   = 6'b010000,
    S_FILL   = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  logic [AW-1:0]  wr_r, wr_nxt;
  logic [AW-1:0]  rd_r, rd_nxt;
  logic           pend_r, pend_nxt;
  logic [RW-1:0]  row_r, row_nxt;
  logic [CLW-1:0] col_r, col_nxt;
  logic           is_read_r, is_read_nxt;
  logic           in_range_r, in_range_nxt;
  logic           scrolled_r, scrolled_nxt;
  logic           load_out;

  logic [RW-1:0]  calc_row;
  logic [CLW-1:0] calc_col;
  logic           calc_scroll;
  logic [AW-1:0]  cur_pos;

  tcw_cursor_next #(
    .COLS (COLS),
    .ROWS (ROWS)
  ) u_cursor_next (
    .row       (row_r),
    .col       (col_r),
    .char_code (in_char_code),
    .row_nxt   (calc_row),
    .col_nxt   (calc_col),
    .scroll    (calc_scroll)
  );

  assign cur_pos  = AW'(AW'(row_r) * COLS_W + AW'(col_r));
  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt    = state_r;
    wr_nxt       = wr_r;
    rd_nxt       = rd_r;
    pend_nxt     = pend_r;
    row_nxt      = row_r;
    col_nxt      = col_r;
    is_read_nxt  = is_read_r;
    in_range_nxt = in_range_r;
    scrolled_nxt = scrolled_r;
    load_out     = 1'b0;
    mem_we       = 1'b0;
    mem_waddr    = wr_r;
    mem_wdata    = {text_attr, CODE_SPACE};
    mem_re       = 1'b0;
    mem_raddr    = rd_r;
    case (state_r)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_wdata = {RESET_ATTR, CODE_SPACE};
        wr_nxt    = wr_r + AW'(1);
        if (wr_r == LAST) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          if (in_func == FUNC_READ) begin
            mem_re       = 1'b1;
            mem_raddr    = AW'(in_cell_index);
            is_read_nxt  = 1'b1;
            in_range_nxt = (CMPW'(in_cell_index) < CMPW'(CELL_COUNT));
            scrolled_nxt = 1'b0;
            state_nxt    = S_FINISH;
          end else begin
            mem_we       = 1'b1;
            mem_waddr    = cur_pos;
            mem_wdata    = {text_attr, in_char_code};
            is_read_nxt  = 1'b0;
            in_range_nxt = 1'b0;
            scrolled_nxt = calc_scroll;
            row_nxt      = calc_row;
            col_nxt      = calc_col;
            if (calc_scroll) begin
              rd_nxt    = COLS_W;
              wr_nxt    = '0;
              pend_nxt  = 1'b0;
              state_nxt = S_COPY;
            end else begin
              state_nxt = S_FINISH;
            end
          end
        end
      end
      S_COPY: begin
        // read one row ahead, write the previous read back one row up
        mem_re    = 1'b1;
        mem_raddr = rd_r;
        if (pend_r) begin
          mem_we    = 1'b1;
          mem_wdata = mem_rdata;
          wr_nxt    = wr_r + AW'(1);
        end
        pend_nxt = 1'b1;
        rd_nxt   = rd_r + AW'(1);
        if (rd_r == LAST) begin
          state_nxt = S_TAIL;
        end
      end
      S_TAIL: begin
        mem_we    = 1'b1;
        mem_wdata = mem_rdata;
        wr_nxt    = wr_r + AW'(1);
        state_nxt = S_FILL;
      end
      S_FILL: begin
        mem_we = 1'b1;
        wr_nxt = wr_r + AW'(1);
        if (wr_r == LAST) begin
          state_nxt = S_FINISH;
        end
      end
      S_FINISH: begin
        // hold until the result register is free
        if (!out_valid || out_ready) begin
          load_out  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      wr_r    <= '0;
      rd_r    <= '0;
      pend_r  <= 1'b0;
      row_r   <= '0;
      col_r   <= '0;
    end else begin
      state_r <= state_nxt;
      wr_r    <= wr_nxt;
      rd_r    <= rd_nxt;
      pend_r  <= pend_nxt;
      row_r   <= row_nxt;
      col_r   <= col_nxt;
    end
  end

  always_ff @(posedge clk) begin
    is_read_r  <= is_read_nxt;
    in_range_r <= in_range_nxt;
    scrolled_r <= scrolled_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_cursor_index <= 11'(cur_pos);
      out_cursor_row   <= 5'(row_r);
      out_cursor_col   <= 7'(col_r);
      out_scrolled     <= scrolled_r;
      out_read_cell    <= (is_read_r && in_range_r) ? mem_rdata : '0;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/text_console_char_writer.sv =====
// ---------------------------------------------------------------------------
// text_console_char_writer
// Character-cell console with a screen store and a cursor.
//
// Input channel (in_valid/in_ready) carries put and read items; every item
// gives one transfer on the result channel (out_valid/out_ready) with the
// cursor after the item, a scroll flag and, for reads, the cell read.
// One item is worked on at a time; in_ready is high only while idle.
// A read, or a put that does not scroll, goes from acceptance to S_FINISH,
// where its result is loaded once the output register is free.
// A put that scrolls copies the screen up one cell a cycle through the single
// store port pair and then blanks the bottom row before its result is loaded.
// After reset a clearing pass writes a blank to every cell, one cell a cycle;
// no item is accepted meanwhile, configuration writes are taken throughout.
// The result sits in an output register; when the receiver stalls, a
// finished item waits there and the next item is still accepted, but its
// result is held back until the register is free.
// text_attribute is written at byte address 0 through the cfg_ APB port.
// ---------------------------------------------------------------------------
`default_nettype none

module text_console_char_writer
  import tcw_pkg::*;
#(
  parameter int SCREEN_COLUMNS = DEF_SCREEN_COLUMNS,
  parameter int SCREEN_ROWS    = DEF_SCREEN_ROWS
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [2:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic      [31:0] cfg_prdata,
  output logic             cfg_pready,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        in_func,
  input  wire logic [7:0]  in_char_code,
  input  wire logic [10:0] in_cell_index,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic      [10:0] out_cursor_index,
  output logic      [4:0]  out_cursor_row,
  output logic      [6:0]  out_cursor_col,
  output logic             out_scrolled,
  output logic      [15:0] out_read_cell
);

  localparam int CELL_COUNT = SCREEN_COLUMNS * SCREEN_ROWS;
  localparam int AW         = $clog2(CELL_COUNT);

  logic [7:0]        text_attr_r;
  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  logic [CELL_W-1:0] mem_wdata;
  logic              mem_re;
  logic [AW-1:0]     mem_raddr;
  logic [CELL_W-1:0] mem_rdata;

  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr[2] == REG_TEXT_ATTR) ? {24'b0, text_attr_r} : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      text_attr_r <= RESET_ATTR;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
                 (cfg_paddr[2] == REG_TEXT_ATTR)) begin
      text_attr_r <= cfg_pwdata[7:0];
    end
  end

  tcw_seq #(
    .COLS (SCREEN_COLUMNS),
    .ROWS (SCREEN_ROWS),
    .AW   (AW)
  ) u_seq (
    .clk              (clk),
    .rst_n            (rst_n),
    .text_attr        (text_attr_r),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_func          (in_func),
    .in_char_code     (in_char_code),
    .in_cell_index    (in_cell_index),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_cursor_index (out_cursor_index),
    .out_cursor_row   (out_cursor_row),
    .out_cursor_col   (out_cursor_col),
    .out_scrolled     (out_scrolled),
    .out_read_cell    (out_read_cell),
    .mem_we           (mem_we),
    .mem_waddr        (mem_waddr),
    .mem_wdata        (mem_wdata),
    .mem_re           (mem_re),
    .mem_raddr        (mem_raddr),
    .mem_rdata        (mem_rdata)
  );

  tcw_screen_mem #(
    .DEPTH (CELL_COUNT),
    .AW    (AW)
  ) u_screen_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

endmodule

`default_nettype wire

// ===== test/text_console_char_writer_tb.sv =====
// ---------------------------------------------------------------------------
// text_console_char_writer_tb
// Self-checking bench for the character-cell console. A shadow screen and
// cursor predict the report for every accepted put or read; each report
// transfer is compared field by field with the oldest prediction. A short
// directed table opens the run, then four random phases follow with
// different idling on both channels and a different text attribute each.
// ---------------------------------------------------------------------------
module text_console_char_writer_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import tcw_pkg::*;

  localparam int COLS          = DEF_SCREEN_COLUMNS;
  localparam int ROWS          = DEF_SCREEN_ROWS;
  localparam int CELLS         = COLS * ROWS;
  localparam int CLK_HALF      = 4;
  localparam int RESET_CYCLES  = 6;
  localparam int DIRECTED_ROWS = 24;
  localparam int PHASE_ITEMS   = 210;
  localparam int SETTLE_CYCLES = 40;
  // A scroll copies the whole screen; allow every item to scroll,
  // plus long gaps and stalls, with plenty of margin.
  localparam int CYCLE_LIMIT   = 20_000_000;

  localparam logic       FUNC_PUT  = ~FUNC_READ;
  localparam logic [2:0] ATTR_ADDR = {REG_TEXT_ATTR, 2'b00};

  typedef struct packed {
    logic [10:0] index;
    logic [4:0]  row;
    logic [6:0]  col;
    logic        scrolled;
    logic [15:0] cell_data;
  } cursor_report_t;

  typedef struct packed {
    logic           func;
    logic [7:0]     char_code;
    logic [10:0]    cell_index;
    logic           has_report;
    cursor_report_t report;
  } directed_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [2:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        in_func = 1'b0;
  logic [7:0]  in_char_code = '0;
  logic [10:0] in_cell_index = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [10:0] out_cursor_index;
  logic [4:0]  out_cursor_row;
  logic [6:0]  out_cursor_col;
  logic        out_scrolled;
  logic [15:0] out_read_cell;

  // Shadow of the screen store, cursor and attribute
  logic [15:0]    shadow_cells [CELLS];
  int unsigned    shadow_row;
  int unsigned    shadow_col;
  logic [7:0]     shadow_attr;
  cursor_report_t expected_reports [$];

  int fail_count = 0;
  int items_sent = 0;
  int cycle_count = 0;
  int sender_idle_pct = 0;
  int receiver_stall_pct = 0;

  text_console_char_writer dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_psel         (cfg_psel),
    .cfg_penable      (cfg_penable),
    .cfg_pwrite       (cfg_pwrite),
    .cfg_paddr        (cfg_paddr),
    .cfg_pwdata       (cfg_pwdata),
    .cfg_prdata       (cfg_prdata),
    .cfg_pready       (cfg_pready),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_func          (in_func),
    .in_char_code     (in_char_code),
    .in_cell_index    (in_cell_index),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_cursor_index (out_cursor_index),
    .out_cursor_row   (out_cursor_row),
    .out_cursor_col   (out_cursor_col),
    .out_scrolled     (out_scrolled),
    .out_read_cell    (out_read_cell)
  );

  always #(CLK_HALF) clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= receiver_stall_pct);
  end

  // Apply one item to the shadow console and return the cursor report.
  function automatic cursor_report_t predict_console_item(logic func, logic [7:0] ch,
                                                          logic [10:0] index);
    int unsigned    r;
    int unsigned    c;
    int             i;
    cursor_report_t rep;
    r = shadow_row;
    c = shadow_col;
    rep = '0;
    if (func == FUNC_READ) begin
      if (index < CELLS) rep.cell_data = shadow_cells[index];
    end else begin
      // Control codes are stored like any other byte
      shadow_cells[r * COLS + c] = {shadow_attr, ch};
      c++;
      if (c >= COLS) begin
        c = 0;
        r++;
      end
      if (ch == CODE_NEWLINE) begin
        c = 0;
        r++;
      end else if (ch == CODE_TAB) begin
        c = ((c + 7) & ~32'd7) + 1;
        if (c >= COLS) begin
          c = 0;
          r++;
        end
      end else if (ch == CODE_BACKSPACE && c != 0) begin
        c = (c >= 2) ? c - 2 : 0;
      end
      // Even a two-row overflow scrolls only once
      if (r >= ROWS) begin
        for (i = 0; i < (ROWS - 1) * COLS; i++) shadow_cells[i] = shadow_cells[i + COLS];
        for (i = (ROWS - 1) * COLS; i < CELLS; i++) shadow_cells[i] = {shadow_attr, CODE_SPACE};
        r = ROWS - 1;
        rep.scrolled = 1'b1;
      end
      shadow_row = r;
      shadow_col = c;
    end
    rep.index = 11'(r * COLS + c);
    rep.row   = 5'(r);
    rep.col   = 7'(c);
    return rep;
  endfunction

  function automatic directed_row_t make_row(logic func, logic [7:0] ch, logic [10:0] index,
                                             logic has_report, int row, int col,
                                             logic [15:0] cell_word);
    directed_row_t d;
    d = '0;
    d.func              = func;
    d.char_code         = ch;
    d.cell_index        = index;
    d.has_report        = has_report;
    d.report.index      = 11'(row * COLS + col);
    d.report.row        = 5'(row);
    d.report.col        = 7'(col);
    d.report.cell_data  = cell_word;
    return d;
  endfunction

  function automatic logic [7:0] random_text_char();
    int pick;
    pick = $urandom_range(19);
    if (pick == 0) return CODE_TAB;
    if (pick == 1) return CODE_BACKSPACE;
    if (pick == 2) return 8'($urandom_range(255));
    return 8'($urandom_range(32, 126));
  endfunction

  function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      $display("%0t ns: %s mismatch, expected 0x%0h, got 0x%0h", $time, name, want, got);
      fail_count++;
    end
  endfunction

  // Called at a falling edge; returns at the falling edge after the transfer.
  task automatic send_item(input logic func, input logic [7:0] ch, input logic [10:0] index,
                           input logic has_report, input cursor_report_t typed_report);
    cursor_report_t rep;
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid      <= 1'b1;
    in_func       <= func;
    in_char_code  <= ch;
    in_cell_index <= index;
    do @(posedge clk); while (!in_ready);
    rep = predict_console_item(func, ch, index);
    expected_reports.push_back(has_report ? typed_report : rep);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic put_byte(input logic [7:0] ch);
    send_item(FUNC_PUT, ch, 11'($urandom_range(2047)), 1'b0, '0);
  endtask

  task automatic read_cell(input logic [10:0] index);
    send_item(FUNC_READ, 8'($urandom_range(255)), index, 1'b0, '0);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (expected_reports.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  // Write the attribute register, then read it back.
  task automatic write_attr(input logic [7:0] value);
    logic [31:0] readback;
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= ATTR_ADDR;
    cfg_pwdata  <= {24'b0, value};
    @(negedge clk) cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    @(negedge clk);
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(negedge clk) cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    readback = cfg_prdata;
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    shadow_attr = value;
    if (readback !== {24'b0, value}) begin
      $display("%0t ns: text_attribute readback mismatch, expected 0x%0h, got 0x%0h",
               $time, value, readback);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin : report_check
    cursor_report_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_reports.size() == 0) begin
        $display("%0t ns: unexpected report, expected none, got index 0x%0h cell 0x%0h",
                 $time, out_cursor_index, out_read_cell);
        fail_count++;
      end else begin
        want = expected_reports.pop_front();
        check_field("cursor_index", 16'(want.index), 16'(out_cursor_index));
        check_field("cursor_row", 16'(want.row), 16'(out_cursor_row));
        check_field("cursor_col", 16'(want.col), 16'(out_cursor_col));
        check_field("scrolled", 16'(want.scrolled), 16'(out_scrolled));
        check_field("read_cell", want.cell_data, out_read_cell);
      end
    end
  end

  initial begin : stimulus
    directed_row_t dir_table [DIRECTED_ROWS];
    int            i;
    int            phase;
    int            kind;
    int            count;
    int            target;
    int            stop_at;
    int            cursor_pos;
    int            span;
    logic [7:0]    attr;
    logic [10:0]   index;

    for (i = 0; i < CELLS; i++) shadow_cells[i] = {RESET_ATTR, CODE_SPACE};
    shadow_row  = 0;
    shadow_col  = 0;
    shadow_attr = RESET_ATTR;

    // Reset contents, out-of-range reads, backspace saturation, tab, newline
    dir_table[0]  = make_row(FUNC_READ, 8'h00, 11'd0, 1'b1, 0, 0, 16'h0720);
    dir_table[1]  = make_row(FUNC_READ, 8'h00, 11'd1999, 1'b1, 0, 0, 16'h0720);
    dir_table[2]  = make_row(FUNC_READ, 8'hFF, 11'd2000, 1'b1, 0, 0, 16'h0000);
    dir_table[3]  = make_row(FUNC_READ, 8'h00, 11'd2047, 1'b1, 0, 0, 16'h0000);
    dir_table[4]  = make_row(FUNC_PUT, 8'h41, 11'd2047, 1'b1, 0, 1, 16'h0000);
    dir_table[5]  = make_row(FUNC_READ, 8'h00, 11'd0, 1'b1, 0, 1, 16'h0741);
    dir_table[6]  = make_row(FUNC_PUT, CODE_BACKSPACE, 11'd0, 1'b1, 0, 0, 16'h0000);
    dir_table[7]  = make_row(FUNC_READ, 8'h00, 11'd1, 1'b1, 0, 0, 16'h0708);
    dir_table[8]  = make_row(FUNC_PUT, CODE_BACKSPACE, 11'd0, 1'b1, 0, 0, 16'h0000);
    dir_table[9]  = make_row(FUNC_READ, 8'h00, 11'd0, 1'b1, 0, 0, 16'h0708);
    dir_table[10] = make_row(FUNC_PUT, CODE_TAB, 11'd0, 1'b1, 0, 9, 16'h0000);
    dir_table[11] = make_row(FUNC_PUT, 8'h00, 11'd0, 1'b1, 0, 10, 16'h0000);
    dir_table[12] = make_row(FUNC_PUT, 8'hFF, 11'd0, 1'b1, 0, 11, 16'h0000);
    dir_table[13] = make_row(FUNC_READ, 8'h00, 11'd10, 1'b1, 0, 11, 16'h07FF);
    dir_table[14] = make_row(FUNC_PUT, CODE_TAB, 11'd0, 1'b1, 0, 17, 16'h0000);
    dir_table[15] = make_row(FUNC_PUT, CODE_NEWLINE, 11'd0, 1'b1, 1, 0, 16'h0000);
    dir_table[16] = make_row(FUNC_READ, 8'h00, 11'd17, 1'b1, 1, 0, 16'h070A);
    dir_table[17] = make_row(FUNC_PUT, CODE_NEWLINE, 11'd0, 1'b1, 2, 0, 16'h0000);
    dir_table[18] = make_row(FUNC_READ, 8'h00, 11'd80, 1'b1, 2, 0, 16'h070A);
    dir_table[19] = make_row(FUNC_PUT, 8'h7F, 11'd1365, 1'b0, 0, 0, 16'h0000);
    dir_table[20] = make_row(FUNC_PUT, 8'h80, 11'd682, 1'b0, 0, 0, 16'h0000);
    dir_table[21] = make_row(FUNC_READ, 8'h55, 11'd160, 1'b0, 0, 0, 16'h0000);
    dir_table[22] = make_row(FUNC_READ, 8'hAA, 11'd9, 1'b0, 0, 0, 16'h0000);
    dir_table[23] = make_row(FUNC_PUT, 8'h55, 11'd1024, 1'b0, 0, 0, 16'h0000);

    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;
    @(negedge clk);
    // Taken during the clearing pass; no item is in flight yet
    write_attr(RESET_ATTR);

    for (i = 0; i < DIRECTED_ROWS; i++) begin
      send_item(dir_table[i].func, dir_table[i].char_code, dir_table[i].cell_index,
                dir_table[i].has_report, dir_table[i].report);
    end

    for (phase = 0; phase < 4; phase++) begin
      wait_drained();
      case (phase)
        0: begin
          attr = 8'hFF;
          sender_idle_pct = 0;
          receiver_stall_pct = 0;
        end
        1: begin
          attr = 8'h00;
          sender_idle_pct = 87;
          receiver_stall_pct = 0;
        end
        2: begin
          attr = 8'($urandom_range(255));
          sender_idle_pct = 0;
          receiver_stall_pct = 87;
        end
        default: begin
          attr = 8'h1E;
          sender_idle_pct = 15;
          receiver_stall_pct = 15;
        end
      endcase
      write_attr(attr);

      stop_at = items_sent + PHASE_ITEMS;
      while (items_sent < stop_at) begin
        kind = $urandom_range(99);
        if (kind < 30) begin
          count = $urandom_range(1, 40);
          repeat (count) put_byte(random_text_char());
        end else if (kind < 45) begin
          // Mostly short runs; now and then enough to push past the bottom row
          count = ($urandom_range(3) == 0) ? $urandom_range(18, 28) : $urandom_range(1, 4);
          repeat (count) put_byte(CODE_NEWLINE);
        end else if (kind < 60) begin
          // Run to near the line end, then hit it with a control code or a printable byte
          target = $urandom_range(COLS - 10, COLS - 1);
          while (shadow_col != target) put_byte(8'($urandom_range(32, 126)));
          case ($urandom_range(3))
            0: put_byte(CODE_TAB);
            1: put_byte(CODE_NEWLINE);
            2: put_byte(CODE_BACKSPACE);
            default: put_byte(8'($urandom_range(32, 126)));
          endcase
        end else if (kind < 85) begin
          count = $urandom_range(1, 4);
          repeat (count) begin
            cursor_pos = shadow_row * COLS + shadow_col;
            span = (cursor_pos < 90) ? cursor_pos : 90;
            case ($urandom_range(4))
              0, 1: index = 11'(cursor_pos - $urandom_range(span));
              2: index = 11'((ROWS - 1) * COLS + $urandom_range(COLS - 1));
              3: index = 11'($urandom_range(CELLS, 2047));
              default: index = 11'($urandom_range(CELLS - 1));
            endcase
            read_cell(index);
          end
        end else begin
          count = $urandom_range(1, 3);
          repeat (count) begin
            send_item(1'($urandom_range(1)), 8'($urandom_range(255)),
                      11'($urandom_range(2047)), 1'b0, '0);
          end
        end
      end
    end

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
